@@ src/pp_pkg.sv @@
// Package for the polygon perimeter block.
// Holds the controller state type and the command and status structs.
// Used by pp_ctrl, pp_dpath and polygon_perimeter; depends on nothing.
package pp_pkg;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIFF = 7'b0000010,
        ST_MULX = 7'b0000100,
        ST_MULY = 7'b0001000,
        ST_SQRT = 7'b0010000,
        ST_ADD  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } pp_state_t;

    typedef struct packed {
        logic load;
        logic sel_close;
        logic diff;
        logic mul_x;
        logic mul_y;
        logic sqrt_step;
        logic add;
        logic emit;
    } pp_cmd_t;

    typedef struct packed {
        logic last;
        logic sqrt_last;
    } pp_status_t;

endpackage

@@ src/pp_vertex_if.sv @@
// Vertex channel of the polygon perimeter block.
// Carries valid, ready and one vertex; no dependencies.
interface pp_vertex_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

@@ src/pp_result_if.sv @@
// Result channel of the polygon perimeter block.
// Carries valid, ready, the perimeter and the saturation flag; no dependencies.
interface pp_result_if #(
    parameter int SUM_WIDTH = 27
);
    logic                 valid;
    logic                 ready;
    logic [SUM_WIDTH-1:0] perimeter;
    logic                 saturated;

    modport source (output valid, output perimeter, output saturated, input ready);
    modport sink (input valid, input perimeter, input saturated, output ready);
endinterface

@@ src/pp_ctrl.sv @@
// Controller of the polygon perimeter block.
// Sequences each edge through difference, squares, root and sum; uses pp_pkg.
module pp_ctrl
    import pp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  pp_status_t status,
    output pp_cmd_t    cmd
);

    pp_state_t state_reg, state_next;
    logic      close_reg, close_next;
    logic      out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        close_next = close_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel_close = close_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    close_next = 1'b0;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (close_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.last)
                begin
                    close_next = 1'b1;
                    state_next = ST_DIFF;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            close_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            close_reg     <= close_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/pp_dpath.sv @@
// Datapath of the polygon perimeter block: vertex store, shared squaring
// multiplier, one-bit-per-cycle square root, saturating sum and result register.
// Uses pp_pkg for the command and status structs.
module pp_dpath
    import pp_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int SUM_WIDTH   = 27
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pp_cmd_t                       cmd,
    output pp_status_t                    status,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic                          last_vertex,
    output logic        [SUM_WIDTH-1:0]   perimeter,
    output logic                          saturated
);

    localparam int W    = COORD_WIDTH;
    localparam int RADW = 2 * W + 2;
    localparam int ROOTW = W + 1;
    localparam int REMW = W + 5;
    localparam int CW   = $clog2(W + 1);
    localparam int AW   = ((SUM_WIDTH > ROOTW) ? SUM_WIDTH : ROOTW) + 1;

    logic signed [W-1:0]    first_x_reg, first_y_reg;
    logic signed [W-1:0]    prev_x_reg, prev_y_reg;
    logic signed [W-1:0]    cur_x_reg, cur_y_reg;
    logic                   last_reg;
    logic                   have_first_reg;
    logic [W-1:0]           dx_reg, dy_reg;
    logic [2*W-1:0]         sq_reg;
    logic [RADW-1:0]        rad_reg;
    logic [REMW-1:0]        rem_reg;
    logic [ROOTW-1:0]       root_reg;
    logic [CW-1:0]          cnt_reg;
    logic [SUM_WIDTH-1:0]   sum_reg;
    logic                   clipped_reg;
    logic [SUM_WIDTH-1:0]   perim_reg;
    logic                   sat_reg;

    logic signed [W-1:0]    ref_x, ref_y;
    logic signed [W:0]      diff_x, diff_y;
    logic [W:0]             mag_x, mag_y;
    logic [W-1:0]           mul_op;
    logic [2*W-1:0]         prod;
    logic [REMW-1:0]        rem_sh, trial;
    logic                   take;
    logic [AW-1:0]          sum_ext, sum_max;

    assign ref_x  = cmd.sel_close ? first_x_reg : prev_x_reg;
    assign ref_y  = cmd.sel_close ? first_y_reg : prev_y_reg;
    assign diff_x = {cur_x_reg[W-1], cur_x_reg} - {ref_x[W-1], ref_x};
    assign diff_y = {cur_y_reg[W-1], cur_y_reg} - {ref_y[W-1], ref_y};
    assign mag_x  = diff_x[W] ? (~diff_x + 1'b1) : diff_x;
    assign mag_y  = diff_y[W] ? (~diff_y + 1'b1) : diff_y;

    assign mul_op = cmd.mul_y ? dy_reg : dx_reg;
    assign prod   = {{W{1'b0}}, mul_op} * {{W{1'b0}}, mul_op};

    assign rem_sh = {rem_reg[REMW-3:0], rad_reg[RADW-1:RADW-2]};
    assign trial  = {{(REMW-ROOTW-2){1'b0}}, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    assign sum_ext = {{(AW-SUM_WIDTH){1'b0}}, sum_reg} + {{(AW-ROOTW){1'b0}}, root_reg};
    assign sum_max = {{(AW-SUM_WIDTH){1'b0}}, {SUM_WIDTH{1'b1}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            have_first_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            have_first_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg <= vertex_x;
            cur_y_reg <= vertex_y;
            last_reg  <= last_vertex;
            if (!have_first_reg)
            begin
                first_x_reg <= vertex_x;
                first_y_reg <= vertex_y;
                prev_x_reg  <= vertex_x;
                prev_y_reg  <= vertex_y;
                sum_reg     <= '0;
                clipped_reg <= 1'b0;
            end
        end
        if (cmd.diff)
        begin
            dx_reg <= mag_x[W-1:0];
            dy_reg <= mag_y[W-1:0];
        end
        if (cmd.mul_x)
        begin
            sq_reg <= prod;
        end
        if (cmd.mul_y)
        begin
            rad_reg  <= {2'b00, sq_reg} + {2'b00, prod};
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[RADW-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOTW-2:0], take};
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.add)
        begin
            if (sum_ext > sum_max)
            begin
                sum_reg     <= {SUM_WIDTH{1'b1}};
                clipped_reg <= 1'b1;
            end
            else
            begin
                sum_reg <= sum_ext[SUM_WIDTH-1:0];
            end
            if (!cmd.sel_close)
            begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
            end
        end
        if (cmd.emit)
        begin
            perim_reg <= sum_reg;
            sat_reg   <= clipped_reg;
        end
    end

    assign status.last      = last_reg;
    assign status.sqrt_last = (cnt_reg == CW'(W));
    assign perimeter        = perim_reg;
    assign saturated        = sat_reg;

endmodule

@@ src/polygon_perimeter.sv @@
// Top level of the polygon perimeter block.
// Joins pp_ctrl and pp_dpath to the vertex and result channels.
// Depends on pp_pkg, pp_vertex_if, pp_result_if, pp_ctrl and pp_dpath.
//
// Vertices arrive on the vertex channel, one per transfer, as signed
// fixed-point coordinates with four fractional bits; last_vertex closes the
// polygon. Each closed polygon gives one transfer on the result channel:
// the perimeter in the same units, saturated at its maximum, and a flag
// that tells whether the sum was clipped.
// Each edge's time is set by the square root, which settles one bit of the
// root per cycle, and by the single squaring multiplier, used once for each
// axis. A vertex is taken only while no edge is in progress, so a new vertex
// waits until the edge of the one before is done. A last vertex also runs
// the closing edge, and only then is its result shown.
// The result is held in an output register: the next polygon's vertices
// are taken while it waits, and only the next result stalls until the
// receiver has taken it. Reset empties the output and starts a new polygon.
module polygon_perimeter
    import pp_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int SUM_WIDTH   = 27
) (
    input  logic        clk,
    input  logic        rst_n,
    pp_vertex_if.sink   vertex,
    pp_result_if.source result
);

    pp_cmd_t    cmd;
    pp_status_t status;

    pp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex.valid),
        .in_ready  (vertex.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pp_dpath #(
        .COORD_WIDTH (COORD_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .vertex_x    (vertex.vertex_x),
        .vertex_y    (vertex.vertex_y),
        .last_vertex (vertex.last_vertex),
        .perimeter   (result.perimeter),
        .saturated   (result.saturated)
    );

    // A clipped sum always reads as the top of the range.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |-> (&result.perimeter))
        else $error("saturated result without full-scale perimeter");

    // After a vertex transfer the block is busy with its edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid && vertex.ready |=> !vertex.ready)
        else $error("vertex taken while an edge is in progress");

    // A new result appears only where the controller loads one.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.emit))
        else $error("result shown without a load of the output register");

endmodule

@@ verif/perimeter_checker.sv @@
// Perimeter checker for the polygon perimeter block.
// Watches the vertex and result channels, predicts each perimeter and compares it.
// Depends on pp_vertex_if and pp_result_if.
module perimeter_checker #(
    parameter int COORD_WIDTH = 16,
    parameter int SUM_WIDTH   = 27
) (
    input  logic  clk,
    input  logic  rst_n,
    pp_vertex_if  vertex,
    pp_result_if  result,
    output int    errors,
    output int    pending
);

    localparam logic [63:0] SUM_MAX = (64'd1 << SUM_WIDTH) - 64'd1;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] perimeter;
        logic                 saturated;
    } perimeter_t;

    perimeter_t perimeter_q[$];

    logic signed [COORD_WIDTH-1:0] first_x = '0;
    logic signed [COORD_WIDTH-1:0] first_y = '0;
    logic signed [COORD_WIDTH-1:0] prev_x = '0;
    logic signed [COORD_WIDTH-1:0] prev_y = '0;
    logic                          have_first = 1'b0;
    logic [SUM_WIDTH-1:0]          running_sum = '0;
    logic                          sum_clipped = 1'b0;
    int                            mismatches = 0;

    assign errors = mismatches;

    function automatic logic [63:0] edge_length(
        logic signed [COORD_WIDTH-1:0] ax, logic signed [COORD_WIDTH-1:0] ay,
        logic signed [COORD_WIDTH-1:0] bx, logic signed [COORD_WIDTH-1:0] by);
        logic signed [COORD_WIDTH+1:0] dx;
        logic signed [COORD_WIDTH+1:0] dy;
        logic [COORD_WIDTH:0]          mx;
        logic [COORD_WIDTH:0]          my;
        logic [127:0]                  square;
        logic [127:0]                  root;
        logic [127:0]                  trial;
        dx = ax - bx;
        dy = ay - by;
        mx = (dx < 0) ? (COORD_WIDTH+1)'(-dx) : (COORD_WIDTH+1)'(dx);
        my = (dy < 0) ? (COORD_WIDTH+1)'(-dy) : (COORD_WIDTH+1)'(dy);
        square = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
        root = '0;
        for (int b = COORD_WIDTH + 1; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= square)
                root = trial;
        end
        return root[63:0];
    endfunction

    function automatic void accumulate(logic [63:0] length);
        logic [63:0] total;
        total = 64'(running_sum) + length;
        if (total > SUM_MAX)
        begin
            total = SUM_MAX;
            sum_clipped = 1'b1;
        end
        running_sum = total[SUM_WIDTH-1:0];
    endfunction

    function automatic void take_vertex(logic signed [COORD_WIDTH-1:0] x,
                                        logic signed [COORD_WIDTH-1:0] y, logic last);
        perimeter_t outcome;
        if (!have_first)
        begin
            first_x = x;
            first_y = y;
            have_first = 1'b1;
            running_sum = '0;
            sum_clipped = 1'b0;
        end
        else
            accumulate(edge_length(x, y, prev_x, prev_y));
        prev_x = x;
        prev_y = y;
        if (last)
        begin
            accumulate(edge_length(x, y, first_x, first_y));
            outcome.perimeter = running_sum;
            outcome.saturated = sum_clipped;
            perimeter_q.insert(perimeter_q.size(), outcome);
            first_x = '0;
            first_y = '0;
            prev_x = '0;
            prev_y = '0;
            have_first = 1'b0;
            running_sum = '0;
            sum_clipped = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(string what, longint expected_value,
                                          longint actual_value);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %0d, got %0d", what, expected_value,
                     actual_value);
    endfunction

    always @(posedge clk)
    begin
        perimeter_t wanted;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (perimeter_q.size() == 0)
                    note_mismatch("unexpected result transfer, perimeter", -1,
                                  longint'(result.perimeter));
                else
                begin
                    wanted = perimeter_q.pop_front();
                    if (result.perimeter !== wanted.perimeter)
                        note_mismatch("perimeter", longint'(wanted.perimeter),
                                      longint'(result.perimeter));
                    if (result.saturated !== wanted.saturated)
                        note_mismatch("saturated", longint'(wanted.saturated),
                                      longint'(result.saturated));
                end
            end
            if (vertex.valid && vertex.ready)
                take_vertex(vertex.vertex_x, vertex.vertex_y, vertex.last_vertex);
        end
        pending <= perimeter_q.size();
    end

endmodule

@@ verif/testbench.sv @@
// Top of the polygon perimeter testbench: clock, reset, vertex stimulus and result stalls.
// Instantiates polygon_perimeter and perimeter_checker, and gives the verdict.
// Depends on pp_vertex_if, pp_result_if, polygon_perimeter and perimeter_checker.
module testbench;

    localparam int COORD_WIDTH = 16;
    localparam int SUM_WIDTH   = 27;
    localparam int RANDOM_VERTICES = 370;
    localparam int LONG_POLYGON = 60;
    localparam int HOLD_CYCLES = 700;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 16'sh7fff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   burst_left = 0;

    always #10 clk = ~clk;

    pp_vertex_if #(.COORD_WIDTH(COORD_WIDTH)) vertex_ch ();
    pp_result_if #(.SUM_WIDTH(SUM_WIDTH)) result_ch ();

    polygon_perimeter #(
        .COORD_WIDTH(COORD_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .vertex(vertex_ch),
        .result(result_ch)
    );

    perimeter_checker #(
        .COORD_WIDTH(COORD_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) perimeter_check (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_ch),
        .result (result_ch),
        .errors (errors),
        .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send_vertex(logic signed [COORD_WIDTH-1:0] x,
                               logic signed [COORD_WIDTH-1:0] y, logic last);
        if (burst_left == 0)
        begin
            vertex_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        vertex_ch.valid <= 1'b1;
        vertex_ch.vertex_x <= x;
        vertex_ch.vertex_y <= y;
        vertex_ch.last_vertex <= last;
        @(posedge clk);
        while (!vertex_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord(
        logic signed [COORD_WIDTH-1:0] near);
        int unsigned choice;
        choice = $urandom_range(0, 9);
        case (choice)
            0, 1, 2: return COORD_WIDTH'($urandom);
            3, 4, 5: return near + COORD_WIDTH'($urandom_range(0, 1023)) - 16'd512;
            6:       return COORD_MIN;
            7:       return COORD_MAX;
            default: return COORD_WIDTH'($urandom_range(0, 63)) - 16'd32;
        endcase
    endfunction

    initial
    begin
        int unsigned taken;
        int unsigned mode;
        int unsigned span;
        logic        held;
        taken = 0;
        held = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            if (!held && taken >= 20)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span)
            begin
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= 1'b0;
                    default: result_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
                if (result_ch.valid && result_ch.ready)
                    taken++;
            end
        end
    end

    initial
    begin
        int                            sent;
        int unsigned                   corners;
        int unsigned                   choice;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        vertex_ch.valid = 1'b0;
        vertex_ch.vertex_x = '0;
        vertex_ch.vertex_y = '0;
        vertex_ch.last_vertex = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-vertex polygons give a zero perimeter.
        send_vertex(16'sd0, 16'sd0, 1'b1);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        // Two vertices: the diagonal counted there and back.
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd48, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd64, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(16'sd5, 16'sd5, 1'b0);
        send_vertex(16'sd5, 16'sd5, 1'b1);
        send_vertex(COORD_MAX, 16'sd0, 1'b0);
        send_vertex(COORD_MIN, 16'sd0, 1'b1);
        send_vertex(-16'sd1, -16'sd1, 1'b0);
        send_vertex(16'sd1, 16'sd1, 1'b0);
        send_vertex(-16'sd1, 16'sd1, 1'b1);

        // A zigzag between opposite corners gives a run of the longest edges.
        for (int i = 0; i < LONG_POLYGON; i++)
        begin
            x = (i % 2 == 1) ? COORD_MAX : COORD_MIN;
            send_vertex(x, x, i == LONG_POLYGON - 1);
        end

        sent = 0;
        while (sent < RANDOM_VERTICES)
        begin
            choice = $urandom_range(0, 9);
            case (choice)
                0:       corners = 1;
                1, 2:    corners = 2;
                9:       corners = $urandom_range(9, 30);
                default: corners = $urandom_range(3, 8);
            endcase
            cx = COORD_WIDTH'($urandom);
            cy = COORD_WIDTH'($urandom);
            for (int i = 0; i < corners; i++)
            begin
                x = pick_coord(cx);
                y = pick_coord(cy);
                send_vertex(x, y, i == corners - 1);
                cx = x;
                cy = y;
                sent++;
            end
        end
        vertex_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ polygon_perimeter.f @@
src/pp_pkg.sv
src/pp_vertex_if.sv
src/pp_result_if.sv
src/pp_ctrl.sv
src/pp_dpath.sv
src/polygon_perimeter.sv
verif/perimeter_checker.sv
verif/testbench.sv
